// ===== hw/rtl/half_single_float_converter_macros.svh =====
// assertion helpers for the converter
`ifndef HALF_SINGLE_FLOAT_CONVERTER_MACROS_SVH
`define HALF_SINGLE_FLOAT_CONVERTER_MACROS_SVH

// implication checked every clock, held off during reset
`define HSF_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define HSF_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== hw/rtl/hsfc_pkg.sv =====
`default_nettype none
package hsfc_pkg;
    localparam logic OP_H2S = 1'b0;
    localparam logic OP_S2H = 1'b1;
    localparam int   NSTG   = 3;

    // stage 1 to stage 2 payload
    typedef struct packed {
        logic        op;
        logic        sign;
        logic [7:0]  ex;
        logic [22:0] man;
        logic        zero;
        logic [3:0]  lz;
    } t_s1;

    // stage 2 to stage 3 payload
    typedef struct packed {
        logic        op;
        logic        sign;
        logic [7:0]  ex;
        logic [23:0] man;
        logic        zero;
        logic [4:0]  sh;
    } t_s2;

    // leading zeros of a 10-bit half mantissa, 0..9 when nonzero, 10 when zero
    function automatic logic [3:0] lzc10(input logic [9:0] m);
        logic [3:0] k;
        k = 4'd10;
        for (int i = 0; i < 10; i++) begin
            if (m[i]) k = 4'(9 - i);
        end
        return k;
    endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/hsfc_pipe.sv =====
`default_nettype none
// three-stage datapath: decode and count, shift amount, assemble
module hsfc_pipe import hsfc_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_en,
    input  wire logic        i_op,
    input  wire logic [31:0] i_value,
    output logic [31:0]      o_converted
);
    t_s1 r_s1;
    t_s2 r_s2;
    logic [31:0] r_out;
    t_s1 n_s1;
    t_s2 n_s2;
    logic [31:0] n_out;

    always_comb begin
        n_s1.op = i_op;
        if (i_op == OP_H2S) begin
            n_s1.sign = i_value[15];
            n_s1.ex   = {3'd0, i_value[14:10]};
            n_s1.man  = {i_value[9:0], 13'd0};
            n_s1.zero = (i_value[14:0] == 15'd0);
        end else begin
            n_s1.sign = i_value[31];
            n_s1.ex   = i_value[30:23];
            n_s1.man  = i_value[22:0];
            n_s1.zero = (i_value[30:0] == 31'd0);
        end
        n_s1.lz = lzc10(i_value[9:0]);
    end

    always_comb begin
        logic signed [9:0] e;
        n_s2.op   = r_s1.op;
        n_s2.sign = r_s1.sign;
        n_s2.ex   = r_s1.ex;
        n_s2.zero = r_s1.zero;
        n_s2.sh   = {1'b0, r_s1.lz};
        n_s2.man  = {1'b0, r_s1.man};
        e = $signed({2'b00, r_s1.ex}) - 10'sd112;
        if (r_s1.op == OP_H2S) begin
            // normalize half subnormal: shift out leading zeros and the hidden one
            if (r_s1.ex == 8'd0)
                n_s2.man = {1'b0, r_s1.man << (r_s1.lz + 4'd1)};
        end else if (e <= 0 && e >= -10) begin
            n_s2.man = {1'b1, r_s1.man};
            n_s2.sh  = 5'(10'sd14 - e);
        end
    end

    always_comb begin
        logic signed [9:0] e;
        logic [23:0] sm;
        e = $signed({2'b00, r_s2.ex}) - 10'sd112;
        sm = r_s2.man >> r_s2.sh;
        n_out = 32'd0;
        if (r_s2.op == OP_H2S) begin
            if (r_s2.zero)
                n_out = {r_s2.sign, 31'd0};
            else if (r_s2.ex == 8'd0)
                n_out = {r_s2.sign, 8'(8'd112 - {4'd0, r_s2.sh}), r_s2.man[22:0]};
            else if (r_s2.ex == 8'd31)
                n_out = {r_s2.sign, 8'hff, r_s2.man[22:0]};
            else
                n_out = {r_s2.sign, 8'(r_s2.ex + 8'd112), r_s2.man[22:0]};
        end else begin
            if (r_s2.zero)
                n_out = {16'd0, r_s2.sign, 15'd0};
            else if (r_s2.ex == 8'hff) begin
                if (r_s2.man[22:0] == 23'd0)
                    n_out = {16'd0, r_s2.sign, 15'h7c00};
                else if (r_s2.man[22:13] == 10'd0)
                    n_out = {16'd0, r_s2.sign, 15'h7dff};
                else
                    n_out = {16'd0, r_s2.sign, 5'h1f, r_s2.man[22:13]};
            end else if (e > 0) begin
                if (e < 31)
                    n_out = {16'd0, r_s2.sign, e[4:0], r_s2.man[22:13]};
                else
                    n_out = {16'd0, r_s2.sign, 15'h7bff};
            end else if (e >= -10)
                n_out = {16'd0, r_s2.sign, 5'd0, sm[9:0]};
            else
                n_out = {16'd0, r_s2.sign, 15'd0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1  <= n_s1;
            r_s2  <= n_s2;
            r_out <= n_out;
        end
    end

    assign o_converted = r_out;
endmodule
`default_nettype wire

// ===== hw/rtl/half_single_float_converter.sv =====
// half/single float converter, three register stages
// path: an accepted word is registered in r_s1, then r_s2, then r_out, from which it leaves
// throughput: one word per cycle; the whole pipe holds while a valid output sees i_stall
// reset: synchronous active-low i_rst_n clears the stage valid bits only
`default_nettype none
`include "half_single_float_converter_macros.svh"
module half_single_float_converter import hsfc_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic        i_op,
    input  wire logic [31:0] i_value,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [31:0]      o_converted
);
    logic [NSTG-1:0] r_vld;
    logic en;

    // pipe advances when the output is free or empty
    assign en      = !(r_vld[NSTG-1] && i_stall);
    assign o_stall = !en;
    assign o_valid = r_vld[NSTG-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NSTG-2:0], i_valid};
        end
    end

    hsfc_pipe u_pipe (
        .i_clk       (i_clk),
        .i_en        (en),
        .i_op        (i_op),
        .i_value     (i_value),
        .o_converted (o_converted)
    );

    `HSF_ASSERT_NXT(a_hold, o_valid && i_stall, o_valid && $stable(o_converted))
    `HSF_ASSERT_IMP(a_stall, o_stall, o_valid && i_stall)
    `HSF_ASSERT_NXT(a_flow, i_valid && !o_stall, r_vld[0])
endmodule
`default_nettype wire
